/* src/hbb_pkg.sv */
// Shared types and constants for the horizontal box blur with alpha blend.
// Used by hbb_front, hbb_queue, hbb_back, the top level, both checkers and the testbench.
package hbb_pkg;

    localparam int MAX_RADIUS_DEFAULT = 20;
    localparam int QUEUE_DEPTH        = 4;

    localparam int STRENGTH_W = 7;
    localparam logic [STRENGTH_W-1:0] STRENGTH_MAX = 7'd100;

    // Field widths sized for the largest supported radius (63)
    localparam int PEND_W = 7;
    localparam int RAD_W  = 6;
    localparam int EMIT_W = 6;
    localparam logic [EMIT_W-1:0] EMIT_SAT = 6'd63;

    // x/5 for x <= 100 as (x*205) >> 10
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_W     = 15;
    localparam int DIV5_SHIFT = 10;

    // Blend: x/100 for x <= 25500 as (x*5243) >> 19
    localparam int BLEND_SCALE   = 100;
    localparam int MIX_W         = 15;
    localparam int DIV100_MUL    = 5243;
    localparam int DIV100_MUL_W  = 13;
    localparam int DIV100_SHIFT  = 19;
    localparam int CHAN_MAX      = 255;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
        logic       row_end;
    } in_pixel_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       out_row_end;
    } out_pixel_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    // One accepted pixel and the outputs it releases
    typedef struct packed {
        pix_t                  pix;
        logic                  row_end;
        logic [PEND_W-1:0]     pend;
        logic [EMIT_W-1:0]     emitted;
        logic [RAD_W-1:0]      radius;
        logic [STRENGTH_W-1:0] weight;
        logic [PEND_W-1:0]     count;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_READ,
        BK_DIV,
        BK_MIX,
        BK_SCALE,
        BK_EMIT
    } back_state_t;

endpackage

/* src/hbb_front.sv */
// Front end: strength register, input acceptance, row bookkeeping.
// Turns each pixel into a job for the back end. Depends on hbb_pkg.
module hbb_front
    import hbb_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [STRENGTH_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_pixel_t             s_data,
    output logic                  job_valid,
    input  logic                  job_ready,
    output job_t                  job
);

    localparam logic [PEND_W-1:0] PEND_CAP = PEND_W'(MAX_RADIUS + 1);
    localparam logic [RAD_W-1:0]  RAD_MAX  = RAD_W'(MAX_RADIUS);
    localparam int                SUM_W    = PEND_W + 1;

    logic [STRENGTH_W-1:0] strength_reg;
    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic [EMIT_W-1:0]     emit_reg, emit_next;

    logic [STRENGTH_W-1:0] eff;
    logic [DIV5_W-1:0]     div5_prod;
    logic [RAD_W-1:0]      rad_raw, radius;
    logic [PEND_W-1:0]     pend_now, count;
    logic [SUM_W-1:0]      emit_sum;
    logic                  accept;

    always_comb begin
        eff       = (strength_reg > STRENGTH_MAX) ? STRENGTH_MAX : strength_reg;
        div5_prod = DIV5_W'(eff) * DIV5_W'(DIV5_MUL);
        rad_raw   = RAD_W'(div5_prod[DIV5_W-1:DIV5_SHIFT]);
        priority if (eff == '0) begin
            radius = '0;
        end else if (rad_raw == '0) begin
            radius = RAD_W'(1);
        end else if (rad_raw > RAD_MAX) begin
            radius = RAD_MAX;
        end else begin
            radius = rad_raw;
        end

        pend_now = (pend_reg < PEND_CAP) ? pend_reg + PEND_W'(1) : pend_reg;
        if (s_data.row_end) begin
            count = pend_now;
        end else if (pend_now > PEND_W'(radius)) begin
            count = pend_now - PEND_W'(radius);
        end else begin
            count = '0;
        end

        emit_sum  = SUM_W'(emit_reg) + SUM_W'(count);
        emit_next = s_data.row_end ? '0
                  : (emit_sum > SUM_W'(EMIT_SAT)) ? EMIT_SAT : emit_sum[EMIT_W-1:0];
        pend_next = s_data.row_end ? '0 : pend_now - count;
    end

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign accept    = s_valid & job_ready;

    always_comb begin
        job.pix.alpha = s_data.in_alpha;
        job.pix.red   = s_data.in_red;
        job.pix.green = s_data.in_green;
        job.pix.blue  = s_data.in_blue;
        job.row_end   = s_data.row_end;
        job.pend      = pend_now;
        job.emitted   = emit_reg;
        job.radius    = radius;
        job.weight    = eff;
        job.count     = count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg <= '0;
            pend_reg     <= '0;
            emit_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                strength_reg <= cfg_wr_data;
            end
            if (accept) begin
                pend_reg <= pend_next;
                emit_reg <= emit_next;
            end
        end
    end

endmodule

/* src/hbb_queue.sv */
// Short job queue between the front and back ends.
// Depends on hbb_pkg for the job type.
module hbb_queue
    import hbb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             push, pop;

    assign push_ready = (fill_reg != FULL_CNT);
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* src/hbb_back.sv */
// Back end: pixel ring memory, serial window sum, bit-serial divide by the
// window count, blend and output register. Depends on hbb_pkg.
module hbb_back
    import hbb_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    output logic       m_valid,
    input  logic       m_ready,
    output out_pixel_t m_data
);

    localparam int RING_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = $clog2(RING_DEPTH * CHAN_MAX + 1);
    localparam int STEP_W     = $clog2(SUM_W + 1);
    localparam int PROD_W     = MIX_W + DIV100_MUL_W;
    localparam int Q_W        = PROD_W - DIV100_SHIFT;

    localparam logic [ADDR_W-1:0]     LAST_ADDR   = ADDR_W'(RING_DEPTH - 1);
    localparam logic [ADDR_W:0]       RING_SPAN   = (ADDR_W + 1)'(RING_DEPTH);
    localparam logic [ADDR_W:0]       BACK_OFS    = (ADDR_W + 1)'(RING_DEPTH - 1);
    localparam logic [STEP_W-1:0]     LAST_STEP   = STEP_W'(SUM_W - 1);
    localparam logic [STRENGTH_W-1:0] FULL_WEIGHT = STRENGTH_W'(BLEND_SCALE);
    localparam logic [Q_W-1:0]        Q_MAX       = Q_W'(CHAN_MAX);

    function automatic logic [7:0] chan_of(pix_t p, int c);
        logic [7:0] v;
        if (c == 0) begin
            v = p.red;
        end else if (c == 1) begin
            v = p.green;
        end else begin
            v = p.blue;
        end
        return v;
    endfunction

    back_state_t state_reg, state_next;

    pix_t ring_mem [RING_DEPTH];
    pix_t rd_data_reg;

    logic [ADDR_W-1:0]     head_reg;
    logic                  row_end_reg;
    logic [PEND_W-1:0]     pend_reg;
    logic [EMIT_W-1:0]     emit_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [STRENGTH_W-1:0] weight_reg;
    logic [PEND_W-1:0]     count_reg;

    logic [ADDR_W-1:0] rd_addr_reg;
    logic [CNT_W-1:0]  rd_rem_reg;
    logic              rd_valid_reg;
    logic [CNT_W-1:0]  ret_idx_reg;
    logic [RAD_W-1:0]  left_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [STEP_W-1:0] step_reg;
    pix_t              centre_reg;

    logic [SUM_W-1:0] sum_reg [3];
    logic [CNT_W-1:0] rem_reg [3];
    logic [MIX_W-1:0] mix_reg [3];
    logic [7:0]       res_reg [3];

    logic       m_valid_reg;
    out_pixel_t m_data_reg;

    logic ring_we, rd_en, out_load;

    // Window geometry of the output at hand
    logic [PEND_W-1:0] d0;
    logic [RAD_W-1:0]  right_w, left_w;
    logic [CNT_W-1:0]  cnt_w;
    logic [ADDR_W:0]   reach, start_raw;
    logic [ADDR_W-1:0] start_addr;

    always_comb begin
        d0         = pend_reg - PEND_W'(1);
        right_w    = (d0 < PEND_W'(rad_reg)) ? RAD_W'(d0) : rad_reg;
        left_w     = (emit_reg < EMIT_W'(rad_reg)) ? RAD_W'(emit_reg) : rad_reg;
        cnt_w      = CNT_W'(left_w) + CNT_W'(right_w) + CNT_W'(1);
        reach      = (ADDR_W + 1)'(d0) + (ADDR_W + 1)'(left_w);
        start_raw  = (ADDR_W + 1)'(head_reg) + BACK_OFS - reach;
        start_addr = (start_raw >= RING_SPAN) ? ADDR_W'(start_raw - RING_SPAN)
                                              : ADDR_W'(start_raw);
    end

    // One restoring divide step per channel
    logic [CNT_W:0]   shifted [3];
    logic             fits    [3];
    logic [CNT_W-1:0] rem_new [3];
    logic [PROD_W-1:0] prod   [3];
    logic [Q_W-1:0]    quot   [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            shifted[c] = {rem_reg[c], sum_reg[c][SUM_W-1]};
            fits[c]    = (shifted[c] >= {1'b0, cnt_reg});
            rem_new[c] = fits[c] ? CNT_W'(shifted[c] - {1'b0, cnt_reg})
                                 : shifted[c][CNT_W-1:0];
            prod[c]    = PROD_W'(mix_reg[c]) * PROD_W'(DIV100_MUL);
            quot[c]    = prod[c][PROD_W-1:DIV100_SHIFT];
        end
    end

    always_comb begin
        state_next = state_reg;
        job_ready  = 1'b0;
        ring_we    = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    ring_we = 1'b1;
                    if (job.count != '0) begin
                        state_next = BK_SETUP;
                    end
                end
            end
            BK_SETUP: state_next = BK_READ;
            BK_READ: begin
                rd_en = (rd_rem_reg != '0);
                // leave once every read has come back
                if (rd_rem_reg == '0 && !rd_valid_reg) begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (step_reg == LAST_STEP) begin
                    state_next = BK_MIX;
                end
            end
            BK_MIX:   state_next = BK_SCALE;
            BK_SCALE: state_next = BK_EMIT;
            BK_EMIT: begin
                out_load = !m_valid_reg || m_ready;
                if (out_load) begin
                    state_next = (count_reg == PEND_W'(1)) ? BK_IDLE : BK_SETUP;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
            if (ring_we) begin
                head_reg <= (head_reg == LAST_ADDR) ? '0 : head_reg + ADDR_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[head_reg] <= job.pix;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    row_end_reg <= job.row_end;
                    pend_reg    <= job.pend;
                    emit_reg    <= job.emitted;
                    rad_reg     <= job.radius;
                    weight_reg  <= job.weight;
                    count_reg   <= job.count;
                end
            end
            BK_SETUP: begin
                rd_addr_reg <= start_addr;
                rd_rem_reg  <= cnt_w;
                cnt_reg     <= cnt_w;
                left_reg    <= left_w;
                ret_idx_reg <= '0;
                step_reg    <= '0;
                for (int c = 0; c < 3; c++) begin
                    sum_reg[c] <= '0;
                    rem_reg[c] <= '0;
                end
            end
            BK_READ: begin
                if (rd_en) begin
                    rd_addr_reg <= (rd_addr_reg == LAST_ADDR) ? '0
                                                              : rd_addr_reg + ADDR_W'(1);
                    rd_rem_reg  <= rd_rem_reg - CNT_W'(1);
                end
                if (rd_valid_reg) begin
                    for (int c = 0; c < 3; c++) begin
                        sum_reg[c] <= sum_reg[c] + SUM_W'(chan_of(rd_data_reg, c));
                    end
                    ret_idx_reg <= ret_idx_reg + CNT_W'(1);
                    // reads run oldest first, so the centre sits left_reg in
                    if (ret_idx_reg == CNT_W'(left_reg)) begin
                        centre_reg <= rd_data_reg;
                    end
                end
            end
            BK_DIV: begin
                for (int c = 0; c < 3; c++) begin
                    sum_reg[c] <= {sum_reg[c][SUM_W-2:0], fits[c]};
                    rem_reg[c] <= rem_new[c];
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            BK_MIX: begin
                for (int c = 0; c < 3; c++) begin
                    mix_reg[c] <= MIX_W'(chan_of(centre_reg, c))
                                      * MIX_W'(FULL_WEIGHT - weight_reg)
                                + MIX_W'(sum_reg[c][7:0]) * MIX_W'(weight_reg);
                end
            end
            BK_SCALE: begin
                for (int c = 0; c < 3; c++) begin
                    res_reg[c] <= (quot[c] > Q_MAX) ? 8'hFF : quot[c][7:0];
                end
            end
            BK_EMIT: begin
                if (out_load) begin
                    m_data_reg.out_red     <= res_reg[0];
                    m_data_reg.out_green   <= res_reg[1];
                    m_data_reg.out_blue    <= res_reg[2];
                    m_data_reg.out_alpha   <= centre_reg.alpha;
                    m_data_reg.out_row_end <= row_end_reg && (pend_reg == PEND_W'(1));
                    pend_reg  <= pend_reg - PEND_W'(1);
                    count_reg <= count_reg - PEND_W'(1);
                    if (emit_reg < EMIT_SAT) begin
                        emit_reg <= emit_reg + EMIT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* src/horizontal_box_blur_blend.sv */
// Flow: an item enters the job queue at its accepting edge; the back end then takes each
// result through the serial window read, the bit-serial divide (SUM_W = 14 at a radius
// limit of 20), blend and output register. Throughput: items are taken one per cycle
// until the 4-entry queue fills; beyond that the pace is set by the back end, which pops
// a job only when idle: by its serial window read on one ring memory port and its divider.
// Reset: synchronous, active low; clears strength, row counts, queue and output valid.
module horizontal_box_blur_blend
    import hbb_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [STRENGTH_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_pixel_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_pixel_t            m_data
);

    logic push_valid, push_ready, pop_valid, pop_ready;
    job_t push_job, pop_job;

    hbb_front #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .job_valid  (push_valid),
        .job_ready  (push_ready),
        .job        (push_job)
    );

    hbb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_job)
    );

    hbb_back #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_valid(pop_valid),
        .job_ready(pop_ready),
        .job      (pop_job),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* src/hbb_checker.sv */
// Port-level checks for horizontal_box_blur_blend, bound to the top level.
// Depends on hbb_pkg for the payload types.
module hbb_checker
    import hbb_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input in_pixel_t             s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_pixel_t            m_data
);

    logic [15:0] items_open_reg;
    logic [15:0] rows_open_reg;
    logic        in_acc, out_acc, in_row, out_row;

    assign in_acc  = s_valid & s_ready;
    assign out_acc = m_valid & m_ready;
    assign in_row  = in_acc & s_data.row_end;
    assign out_row = out_acc & m_data.out_row_end;

    // Track items and rows taken in but not yet fully delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            items_open_reg <= '0;
            rows_open_reg  <= '0;
        end else begin
            items_open_reg <= items_open_reg + 16'(in_acc) - 16'(out_acc);
            rows_open_reg  <= rows_open_reg + 16'(in_row) - 16'(out_row);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_no_extra_item: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> items_open_reg != '0)
        else $error("more results than accepted items");

    a_row_end_source: assert property (@(posedge aclk) disable iff (!aresetn)
        out_row |-> rows_open_reg != '0)
        else $error("row end delivered without an accepted row end");

    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && items_open_reg == 16'd1 |=> items_open_reg == '0 || $past(in_acc))
        else $error("item count lost track after the last result");

endmodule

bind horizontal_box_blur_blend hbb_checker u_hbb_checker (.*);

/* sim/blur_blend_checker.sv */
// Checker for horizontal_box_blur_blend: follows strength writes, predicts the blurred and
// blended pixels released by each accepted input item and compares results in order.
// Depends on hbb_pkg for the pixel payload types and blend constants.
`timescale 1ns / 1ps

module blur_blend_checker
    import hbb_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [STRENGTH_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_pixel_t             s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_pixel_t            m_data,
    output int                    mismatches,
    output int                    awaited
);

    localparam int RING_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int RADIUS_STEP = 5;

    logic [STRENGTH_W-1:0] strength_q;
    pix_t                  row_pixels [RING_DEPTH];
    int                    ring_wr;
    int                    held_count;
    int                    row_emitted;
    out_pixel_t            expected_pixels [$];
    out_pixel_t            want;

    function automatic pix_t pixel_ago(input int d);
        return row_pixels[(ring_wr + RING_DEPTH - 1 - (d % RING_DEPTH)) % RING_DEPTH];
    endfunction

    function automatic logic [7:0] mix_channel(input int orig, input int avg, input int w);
        int v;
        v = (orig * (BLEND_SCALE - w) + avg * w) / BLEND_SCALE;
        return (v > CHAN_MAX) ? 8'(CHAN_MAX) : 8'(v);
    endfunction

    // Emit the oldest held pixel, averaged over its window clipped to the row seen so far
    task automatic release_pixel(input int radius, input int weight, input logic last);
        int         d0;
        int         right;
        int         left;
        int         cnt;
        int         sum_r;
        int         sum_g;
        int         sum_b;
        pix_t       centre;
        pix_t       p;
        out_pixel_t res;
        d0     = held_count - 1;
        right  = (d0 < radius) ? d0 : radius;
        left   = (row_emitted < radius) ? row_emitted : radius;
        cnt    = left + right + 1;
        centre = pixel_ago(d0);
        sum_r  = 0;
        sum_g  = 0;
        sum_b  = 0;
        for (int d = d0 - right; d <= d0 + left; d++) begin
            p = pixel_ago(d);
            sum_r += p.red;
            sum_g += p.green;
            sum_b += p.blue;
        end
        res.out_red     = mix_channel(centre.red, sum_r / cnt, weight);
        res.out_green   = mix_channel(centre.green, sum_g / cnt, weight);
        res.out_blue    = mix_channel(centre.blue, sum_b / cnt, weight);
        res.out_alpha   = centre.alpha;
        res.out_row_end = last;
        expected_pixels.push_back(res);
        held_count--;
        if (row_emitted < EMIT_SAT)
            row_emitted++;
    endtask

    task automatic predict_pixel(input in_pixel_t px);
        int weight;
        int radius;
        weight = (strength_q > STRENGTH_MAX) ? int'(STRENGTH_MAX) : int'(strength_q);
        if (weight == 0) begin
            radius = 0;
        end else begin
            radius = weight / RADIUS_STEP;
            if (radius < 1)
                radius = 1;
            if (radius > MAX_RADIUS)
                radius = MAX_RADIUS;
        end
        row_pixels[ring_wr] = {px.in_alpha, px.in_red, px.in_green, px.in_blue};
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (held_count < MAX_RADIUS + 1)
            held_count++;
        if (px.row_end) begin
            // flush the whole row, flag only its final pixel
            while (held_count > 0)
                release_pixel(radius, weight, held_count == 1);
            row_emitted = 0;
        end else begin
            while (held_count > radius)
                release_pixel(radius, weight, 1'b0);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            strength_q  = '0;
            ring_wr     = 0;
            held_count  = 0;
            row_emitted = 0;
            mismatches  = 0;
            foreach (row_pixels[i])
                row_pixels[i] = '0;
            expected_pixels.delete();
        end else begin
            // an item taken at the same edge as a write still sees the old strength
            if (s_valid && s_ready)
                predict_pixel(s_data);
            if (cfg_wr_en)
                strength_q = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t ns: expected no item, got r=%0d g=%0d b=%0d a=%0d end=%0d",
                             $time, m_data.out_red, m_data.out_green, m_data.out_blue,
                             m_data.out_alpha, m_data.out_row_end);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("out_red", want.out_red, m_data.out_red);
                    check_field("out_green", want.out_green, m_data.out_green);
                    check_field("out_blue", want.out_blue, m_data.out_blue);
                    check_field("out_alpha", want.out_alpha, m_data.out_alpha);
                    check_field("out_row_end", want.out_row_end, m_data.out_row_end);
                end
            end
        end
        awaited = expected_pixels.size();
    end

endmodule

/* sim/horizontal_box_blur_blend_tb.sv */
// Testbench top for horizontal_box_blur_blend: clock, reset, pixel stimulus, strength
// writes and output back-pressure. Depends on hbb_pkg and blur_blend_checker.
`timescale 1ns / 1ps

module horizontal_box_blur_blend_tb;
    import hbb_pkg::*;

    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 200;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_GAP     = 18;
    localparam int LONG_ROW    = 70;
    localparam int PHASE_ITEMS = 11;
    localparam logic [STRENGTH_W-1:0] STRENGTH_TOP = '1;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [STRENGTH_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    in_pixel_t             s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_pixel_t            m_data;
    int                    mismatches;
    int                    awaited;
    bit                    idle_on   = 1'b1;
    bit                    long_hold = 1'b0;
    int                    row_left  = 0;

    horizontal_box_blur_blend u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    blur_blend_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .awaited     (awaited)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold && !hold_done) begin
                // back up the block until it stops taking input
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic in_pixel_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [7:0] a,
                                           input logic last);
        return '{r, g, b, a, last};
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_pixel_t rand_pixel(input logic last);
        return '{rand_chan(), rand_chan(), rand_chan(), rand_chan(), last};
    endfunction

    function automatic logic [STRENGTH_W-1:0] pick_strength();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return STRENGTH_MAX;
            2: return STRENGTH_TOP;
            3: return STRENGTH_W'($urandom_range(1, 9));
            default: return STRENGTH_W'($urandom_range(0, 127));
        endcase
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance.
    task automatic send_pixel(input in_pixel_t px);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_strength(input logic [STRENGTH_W-1:0] level);
        s_valid <= 1'b0;
        while (awaited != 0)
            @(negedge aclk);
        // items that release nothing may still be in flight
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input logic [STRENGTH_W-1:0] level, input int n_items,
                                input bit end_row, input int long_len, input bit squeeze);
        logic last;
        write_strength(level);
        if (squeeze)
            long_hold <= 1'b1;
        if (long_len > 0)
            row_left = long_len;
        for (int i = 0; i < n_items; i++) begin
            if (row_left == 0)
                row_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 30);
            row_left--;
            last = (row_left == 0) || (end_row && i == n_items - 1);
            if (last)
                row_left = 0;
            send_pixel(rand_pixel(last));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // strength still at its reset value: straight pass-through
        send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_pixel(mk_pixel(8'h55, 8'hAA, 8'h0F, 8'hF0, 1'b1));

        // full strength: window spans the whole short row
        write_strength(STRENGTH_MAX);
        for (int i = 0; i < 5; i++)
            send_pixel(mk_pixel((i % 2) ? 8'h00 : 8'hFF, (i % 2) ? 8'hFF : 8'h00,
                                8'(i * 60), 8'hA5, i == 4));

        // above range clamps to full strength
        write_strength(STRENGTH_TOP);
        send_pixel(mk_pixel(8'hFF, 8'h00, 8'h80, 8'h01, 1'b0));
        send_pixel(mk_pixel(8'h00, 8'hFF, 8'h7F, 8'hFE, 1'b0));
        send_pixel(mk_pixel(8'h01, 8'h80, 8'hFF, 8'h00, 1'b1));

        // weakest blur: single-pixel row, then a short row
        write_strength(STRENGTH_W'(1));
        send_pixel(mk_pixel(8'hFF, 8'h00, 8'hFF, 8'h80, 1'b1));
        for (int i = 0; i < 3; i++)
            send_pixel(mk_pixel(8'(i * 120), 8'(255 - i * 100), 8'hC3, 8'(i), i == 2));

        // shrink the radius inside a row
        write_strength(STRENGTH_W'(50));
        for (int i = 0; i < 4; i++)
            send_pixel(rand_pixel(1'b0));
        write_strength(STRENGTH_W'(5));
        send_pixel(rand_pixel(1'b0));
        send_pixel(rand_pixel(1'b1));

        // drop to bypass inside a row
        write_strength(STRENGTH_W'(20));
        for (int i = 0; i < 3; i++)
            send_pixel(rand_pixel(1'b0));
        write_strength('0);
        send_pixel(rand_pixel(1'b1));

        for (int ph = 0; ph < 6; ph++) begin
            idle_on <= (ph != 5) && ((ph % 2 == 0) || ($urandom_range(0, 1) == 1));
            random_phase((ph == 2) ? STRENGTH_W'(12) : pick_strength(),
                         (ph == 1) ? LONG_ROW : PHASE_ITEMS,
                         (ph == 5) || ($urandom_range(0, 1) == 1),
                         (ph == 1) ? LONG_ROW : 0,
                         ph == 2);
        end

        s_valid <= 1'b0;
        while (awaited != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (mismatches == 0 && awaited == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* horizontal_box_blur_blend.f */
src/hbb_pkg.sv
src/hbb_front.sv
src/hbb_queue.sv
src/hbb_back.sv
src/horizontal_box_blur_blend.sv
src/hbb_checker.sv
sim/blur_blend_checker.sv
sim/horizontal_box_blur_blend_tb.sv
